### design/pfa_pkg.sv
// Shared constants, types and codes for the physical frame allocator.
package pfa_pkg;

    localparam int LOW_FRAMES  = 4096;
    localparam int CACHE_DEPTH = 16;
    localparam int STACK_DEPTH = 4096;

    localparam int FRAME_W   = 20;
    localparam int COUNT_W   = 13;
    localparam int BIT_W     = 5;
    localparam int WORD_W    = 32;
    localparam int LOW_IDX_W = $clog2(LOW_FRAMES);
    localparam int POS_W     = $clog2(LOW_FRAMES + 1);
    localparam int MAP_WORDS = (LOW_FRAMES + WORD_W - 1) / WORD_W;
    localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CACHE_AW  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int FILL_W    = $clog2(CACHE_DEPTH + 1);
    localparam int STACK_AW  = $clog2(STACK_DEPTH);
    localparam int SCNT_W    = $clog2(STACK_DEPTH + 1);
    localparam int LCNT_W    = $clog2(LOW_FRAMES + 1);

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_MEMORY  = 2'd1;
    localparam logic [1:0] ST_BAD_FRAME  = 2'd2;
    localparam logic [1:0] ST_STACK_FULL = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic POOL_LOW   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_BIT,
        S_POP_RD,
        S_POP_WAIT,
        S_MAP_RD,
        S_MAP_WAIT,
        S_HPOP_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                rd_en;
        logic [MAP_AW-1:0]   rd_addr;
        logic                wr_en;
        logic [MAP_AW-1:0]   wr_addr;
        logic [WORD_W-1:0]   wr_data;
    } map_req_t;

endpackage

### design/physical_frame_allocator.sv
// Top level of the physical frame allocator: control sequencer and pool state.
// Each beat allocates or frees one frame in the high stack pool or the low bitmap pool and
// yields one result beat. One item is handled at a time. Each low step is a read-modify-write
// of a 32-bit bitmap word in a memory with a registered read. A low allocate that finds the
// free cache empty first scans the bitmap from the search position, one frame per cycle
// apart from a pause to read each new bitmap word, until the cache is full or the pool end
// is reached. The bitmap starts with every frame used and needs no clearing pass; the next
// item is taken while a finished result still waits on the output.
module physical_frame_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic                          s_pool,
    input  logic [pfa_pkg::FRAME_W-1:0]   s_frame,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pfa_pkg::FRAME_W-1:0]   m_frame_out,
    output logic [1:0]                    m_status,
    output logic [pfa_pkg::COUNT_W-1:0]   m_free_low_count,
    output logic [pfa_pkg::COUNT_W-1:0]   m_free_high_count
);
    import pfa_pkg::*;

    state_t state_reg, state_next;

    logic                 kind_reg, pool_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [LOW_IDX_W-1:0] cur_reg, cur_next;
    logic [FRAME_W-1:0]   got_reg, got_next;
    logic [1:0]           status_reg, status_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [SCNT_W-1:0]    scnt_reg, scnt_next;
    logic [LCNT_W-1:0]    lcnt_reg, lcnt_next;

    logic                 m_valid_reg;
    logic [FRAME_W-1:0]   m_frame_reg;
    logic [1:0]           m_status_reg;
    logic [COUNT_W-1:0]   m_low_reg, m_high_reg;

    map_req_t             map_req;
    logic [WORD_W-1:0]    map_rdata;

    logic                 c_wr_en, c_rd_en;
    logic [CACHE_AW-1:0]  c_wr_addr, c_rd_addr;
    logic [LOW_IDX_W-1:0] c_wr_data, c_rd_data;

    logic                 h_wr_en, h_rd_en;
    logic [STACK_AW-1:0]  h_wr_addr, h_rd_addr;
    logic [FRAME_W-1:0]   h_rd_data;

    logic                 accept, out_free, scan_bit_used, cur_bit_used, frame_in_range;
    logic [BIT_W-1:0]     pos_bit, cur_bit;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign pos_bit  = pos_reg[BIT_W-1:0];
    assign cur_bit  = cur_reg[BIT_W-1:0];
    assign scan_bit_used  = map_rdata[pos_bit];
    assign cur_bit_used   = map_rdata[cur_bit];
    assign frame_in_range = ({12'd0, frame_reg} < (FRAME_W + 12)'(LOW_FRAMES));

    pfa_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (map_req),
        .rd_data (map_rdata)
    );

    pfa_ram #(.DEPTH(CACHE_DEPTH), .WIDTH(LOW_IDX_W)) u_cache (
        .aclk    (aclk),
        .wr_en   (c_wr_en),
        .wr_addr (c_wr_addr),
        .wr_data (c_wr_data),
        .rd_en   (c_rd_en),
        .rd_addr (c_rd_addr),
        .rd_data (c_rd_data)
    );

    pfa_ram #(.DEPTH(STACK_DEPTH), .WIDTH(FRAME_W)) u_stack (
        .aclk    (aclk),
        .wr_en   (h_wr_en),
        .wr_addr (h_wr_addr),
        .wr_data (frame_reg),
        .rd_en   (h_rd_en),
        .rd_addr (h_rd_addr),
        .rd_data (h_rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (pool_reg == POOL_LOW) begin
                    if (kind_reg == KIND_ALLOC) begin
                        state_next = (fill_reg == '0) ? S_SCAN_RD : S_POP_RD;
                    end else begin
                        state_next = frame_in_range ? S_MAP_RD : S_FINISH;
                    end
                end else if (kind_reg == KIND_ALLOC && scnt_reg != '0) begin
                    state_next = S_HPOP_WAIT;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN_RD: begin
                state_next = (pos_reg < POS_W'(LOW_FRAMES)) ? S_SCAN_BIT : S_POP_RD;
            end
            S_SCAN_BIT: begin
                if (!scan_bit_used && (fill_reg + 1'b1) >= FILL_W'(CACHE_DEPTH)) begin
                    state_next = S_POP_RD;
                end else if (pos_bit == '1) begin
                    state_next = S_SCAN_RD;
                end
            end
            S_POP_RD:    state_next = (fill_reg == '0) ? S_FINISH : S_POP_WAIT;
            S_POP_WAIT:  state_next = S_MAP_RD;
            S_MAP_RD:    state_next = S_MAP_WAIT;
            S_MAP_WAIT:  state_next = S_FINISH;
            S_HPOP_WAIT: state_next = S_FINISH;
            S_FINISH: begin
                if (out_free) state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        cur_next    = cur_reg;
        got_next    = got_reg;
        status_next = status_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        scnt_next   = scnt_reg;
        lcnt_next   = lcnt_reg;
        map_req     = '0;
        c_wr_en     = 1'b0;
        c_wr_addr   = fill_reg[CACHE_AW-1:0];
        c_wr_data   = cur_reg;
        c_rd_en     = 1'b0;
        c_rd_addr   = CACHE_AW'(fill_reg - 1'b1);
        h_wr_en     = 1'b0;
        h_wr_addr   = scnt_reg[STACK_AW-1:0];
        h_rd_en     = 1'b0;
        h_rd_addr   = STACK_AW'(scnt_reg - 1'b1);
        case (state_reg)
            S_IDLE: begin
                got_next    = '0;
                status_next = ST_OK;
            end
            S_DISPATCH: begin
                cur_next = frame_reg[LOW_IDX_W-1:0];
                if (pool_reg == POOL_LOW) begin
                    if (kind_reg != KIND_ALLOC && !frame_in_range) begin
                        status_next = ST_BAD_FRAME;
                    end
                end else if (kind_reg == KIND_ALLOC) begin
                    if (scnt_reg == '0) begin
                        status_next = ST_NO_MEMORY;
                    end else begin
                        h_rd_en   = 1'b1;
                        scnt_next = scnt_reg - 1'b1;
                    end
                end else if (scnt_reg >= SCNT_W'(STACK_DEPTH)) begin
                    status_next = ST_STACK_FULL;
                end else begin
                    h_wr_en   = 1'b1;
                    scnt_next = scnt_reg + 1'b1;
                end
            end
            S_SCAN_RD: begin
                map_req.rd_en   = (pos_reg < POS_W'(LOW_FRAMES));
                map_req.rd_addr = MAP_AW'(pos_reg >> BIT_W);
            end
            S_SCAN_BIT: begin
                c_wr_data = pos_reg[LOW_IDX_W-1:0];
                if (!scan_bit_used) begin
                    c_wr_en   = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                // a full cache leaves the position on the frame just cached
                if (scan_bit_used || (fill_reg + 1'b1) < FILL_W'(CACHE_DEPTH)) begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_POP_RD: begin
                if (fill_reg == '0) begin
                    status_next = ST_NO_MEMORY;
                end else begin
                    c_rd_en   = 1'b1;
                end
            end
            S_POP_WAIT: begin
                cur_next  = c_rd_data;
                got_next  = FRAME_W'(c_rd_data);
                fill_next = fill_reg - 1'b1;
            end
            S_MAP_RD: begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = MAP_AW'(cur_reg >> BIT_W);
            end
            S_MAP_WAIT: begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = MAP_AW'(cur_reg >> BIT_W);
                map_req.wr_data = map_rdata;
                if (kind_reg == KIND_ALLOC) begin
                    map_req.wr_data[cur_bit] = 1'b1;
                    if (!cur_bit_used && lcnt_reg != '0) lcnt_next = lcnt_reg - 1'b1;
                end else begin
                    map_req.wr_data[cur_bit] = 1'b0;
                    if (cur_bit_used) lcnt_next = lcnt_reg + 1'b1;
                    if (fill_reg < FILL_W'(CACHE_DEPTH)) begin
                        c_wr_en   = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            S_HPOP_WAIT: begin
                got_next = h_rd_data;
            end
            S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= s_kind;
            pool_reg  <= s_pool;
            frame_reg <= s_frame;
        end
        cur_reg    <= cur_next;
        got_reg    <= got_next;
        status_reg <= status_next;
        if (state_reg == S_FINISH && out_free) begin
            m_frame_reg  <= got_reg;
            m_status_reg <= status_reg;
            m_low_reg    <= COUNT_W'(lcnt_reg);
            m_high_reg   <= COUNT_W'(scnt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            pos_reg     <= '0;
            scnt_reg    <= '0;
            lcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            scnt_reg  <= scnt_next;
            lcnt_reg  <= lcnt_next;
            if (state_reg == S_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_frame_out       = m_frame_reg;
    assign m_status          = m_status_reg;
    assign m_free_low_count  = m_low_reg;
    assign m_free_high_count = m_high_reg;
endmodule

### design/pfa_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module pfa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 12
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

### design/pfa_map.sv
// Low pool used-bitmap: word memory with per-row valid flags, unwritten rows read as all used.
module pfa_map (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pfa_pkg::map_req_t        req,
    output logic [pfa_pkg::WORD_W-1:0] rd_data
);
    import pfa_pkg::*;

    logic [WORD_W-1:0]    mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] row_valid_reg;
    logic [WORD_W-1:0]    mem_q_reg;
    logic                 hit_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            mem_q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            hit_reg       <= 1'b0;
        end else begin
            if (req.wr_en) begin
                row_valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                hit_reg <= row_valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? mem_q_reg : '1;
endmodule
